[rtl/scnl_pkg.sv]
// Shared constants, codes and control/status types for the sort and condense block.
`default_nettype none
package scnl_pkg;

  // Store capacity and value width.
  localparam int MAX_ENTRIES = 16;
  localparam int VALUE_BITS  = 10;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Separator codes carried with each token.
  typedef enum logic [1:0] {
    SEP_NONE  = 2'd0,
    SEP_COMMA = 2'd1,
    SEP_DASH  = 2'd2
  } sep_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic shift;
    logic emit;
    sep_t sep;
    logic final_tok;
    logic clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic head_range;
    logic head_seq;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/sort_and_condense_number_list.sv]
// Top level of the sorting range condenser.
// Usage:
// - Input channel: an item (in_ref_value, in_set_end) is taken at a rising edge with
//   start high and busy low. Items without in_set_end are taken one per cycle and
//   inserted into an ascending register chain of MAX_ENTRIES entries in that cycle.
// - Items that arrive while the chain is full are dropped; out_overflow is then set
//   on every token of that set.
// - The item with in_set_end is stored first, then busy rises while the controller
//   drains the chain from its head, one entry a cycle. Entries inside a run of three
//   or more consecutive values yield no token.
// - Result channel: each token appears for exactly one cycle with out_valid high.
//   The first token follows set_end via state and token registers; out_final_token
//   marks the last one, and busy is low in that same cycle, so a new set can start.
// - The receiver cannot stall; tokens must be taken as they appear.
// - Reset (rst_n low, synchronous) empties the list, clears the drop flag and
//   returns the controller to idle.
`default_nettype none
module sort_and_condense_number_list (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [scnl_pkg::VALUE_BITS-1:0] in_ref_value,
  input  logic                            in_set_end,
  output logic                            out_valid,
  output logic [scnl_pkg::VALUE_BITS-1:0] out_token_value,
  output logic [1:0]                      out_separator,
  output logic                            out_overflow,
  output logic                            out_final_token
);
  import scnl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing of load and emission.
  scnl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_set_end (in_set_end),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Sorted store and token registers.
  scnl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_ref_value    (in_ref_value),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_token_value (out_token_value),
    .out_separator   (out_separator),
    .out_overflow    (out_overflow),
    .out_final_token (out_final_token)
  );

endmodule
`default_nettype wire

[rtl/scnl_datapath.sv]
// Datapath: sorted register chain, entry count, drop flag and token output registers.
`default_nettype none
module scnl_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scnl_pkg::dp_cmd_t            cmd,
  input  logic [scnl_pkg::VALUE_BITS-1:0] in_ref_value,
  output scnl_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  output logic [scnl_pkg::VALUE_BITS-1:0] out_token_value,
  output logic [1:0]                   out_separator,
  output logic                         out_overflow,
  output logic                         out_final_token
);
  import scnl_pkg::*;

  logic [VALUE_BITS-1:0] store_r   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] store_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  full;
  logic [MAX_ENTRIES-1:0] le;
  logic [VALUE_BITS:0]   head_p1, head_p2;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] tok_r;
  logic [1:0]            sep_r;
  logic                  ovf_r;
  logic                  fin_r;

  assign full = (cnt_r >= CNT_W'(MAX_ENTRIES));

  // Each held entry that is not above the new value keeps its place.
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      le[k] = (CNT_W'(k) < cnt_r) && (store_r[k] <= in_ref_value);
    end
  end

  // Next store: insert by shifting the upper part up, or drain by shifting down.
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      store_nxt[k] = store_r[k];
    end
    if (cmd.insert && !full) begin
      // The bottom entry either stays or takes the new value.
      store_nxt[0] = le[0] ? store_r[0] : in_ref_value;
      for (int k = 1; k < MAX_ENTRIES; k++) begin
        if (le[k]) begin
          store_nxt[k] = store_r[k];
        end else if (le[k-1]) begin
          store_nxt[k] = in_ref_value;
        end else begin
          store_nxt[k] = store_r[k-1];
        end
      end
    end else if (cmd.shift) begin
      for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
        store_nxt[k] = store_r[k+1];
      end
    end
  end

  // Entry count and drop flag.
  always_comb begin
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    if (cmd.clear) begin
      cnt_nxt     = '0;
      dropped_nxt = 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (cmd.shift) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Head-of-list status, compared one bit wider so the top value never wraps.
  assign head_p1 = {1'b0, store_r[0]} + (VALUE_BITS+1)'(1);
  assign head_p2 = {1'b0, store_r[0]} + (VALUE_BITS+1)'(2);

  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.cnt_one    = (cnt_r == CNT_W'(1));
  assign stat.head_seq   = (cnt_r >= CNT_W'(2)) && ({1'b0, store_r[1]} == head_p1);
  assign stat.head_range = (cnt_r >= CNT_W'(3)) && ({1'b0, store_r[1]} == head_p1)
                           && ({1'b0, store_r[2]} == head_p2);

  // Store registers hold no reset value.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      store_r[k] <= store_nxt[k];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Token payload registers: value from the head of the list, flags from the command and drop flag.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tok_r <= store_r[0];
      sep_r <= cmd.sep;
      ovf_r <= dropped_r;
      fin_r <= cmd.final_tok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_value = tok_r;
  assign out_separator   = sep_r;
  assign out_overflow    = ovf_r;
  assign out_final_token = fin_r;

endmodule
`default_nettype wire

[rtl/scnl_ctrl.sv]
// Controller: loads items, then walks the sorted list and emits a token for each entry outside range interiors.
`default_nettype none
module scnl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_set_end,
  input  scnl_pkg::dp_stat_t stat,
  output scnl_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import scnl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EMIT  = 3'b010,
    ST_RANGE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.sep       = SEP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.insert = 1'b1;
          if (in_set_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat.cnt_zero) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.head_range) begin
          // Range opens: emit its first value with a dash.
          cmd.emit  = 1'b1;
          cmd.sep   = SEP_DASH;
          cmd.shift = 1'b1;
          state_nxt = ST_RANGE;
        end else begin
          cmd.emit      = 1'b1;
          cmd.sep       = stat.cnt_one ? SEP_NONE : SEP_COMMA;
          cmd.final_tok = stat.cnt_one;
          cmd.shift     = 1'b1;
          if (stat.cnt_one) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RANGE: begin
        if (stat.head_seq) begin
          // Interior of a range: skip the entry.
          cmd.shift = 1'b1;
        end else begin
          // Range end cannot open another range, so emit it as a plain value.
          cmd.emit      = 1'b1;
          cmd.sep       = stat.cnt_one ? SEP_NONE : SEP_COMMA;
          cmd.final_tok = stat.cnt_one;
          cmd.shift     = 1'b1;
          if (stat.cnt_one) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

[rtl/scnl_checker.sv]
// Port-level checker for the sorting range condenser and its bind statement.
`default_nettype none
module scnl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_set_end,
  input logic                            out_valid,
  input logic [1:0]                      out_separator,
  input logic                            out_final_token
);
  import scnl_pkg::*;

  // A set end always leads to an emission phase.
  a_set_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_set_end |=> busy)
    else $error("set end item did not start emission");

  // The last token ends the emission phase.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_token |-> !busy)
    else $error("busy still high on the last token");

  // A token that is not the last leaves the block busy.
  a_nonfinal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_token |-> busy)
    else $error("block idle after a non-final token");

  // A dash always has a range end after it, and only the last token has no separator.
  a_dash_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_separator == SEP_DASH) |-> !out_final_token)
    else $error("range opened on the last token");

  a_none_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_separator == SEP_NONE) |-> out_final_token)
    else $error("token without separator is not the last");

endmodule

bind sort_and_condense_number_list scnl_checker u_scnl_checker (.*);
`default_nettype wire

[dv/sort_and_condense_number_list_tb.sv]
// Self-checking testbench for the sort and condense block: sets of numbers in, tokens checked.
module sort_and_condense_number_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scnl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 100;
  localparam logic [VALUE_BITS-1:0] TOP_VALUE = '1;

  // One number of a set as it goes to the block.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  set_end;
  } number_item_t;

  // One condensed token as the block should emit it.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    sep_t                  sep;
    logic                  overflow;
    logic                  last;
  } token_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_ref_value = '0;
  logic                  in_set_end = 1'b0;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_token_value;
  logic [1:0]            out_separator;
  logic                  out_overflow;
  logic                  out_final_token;

  number_item_t items_to_send[$];
  token_t       tokens_due[$];

  // Model copy of the sorted chain.
  logic [VALUE_BITS-1:0] list_entries[MAX_ENTRIES];
  int                    list_count = 0;
  logic                  list_dropped = 1'b0;

  int           fail_count = 0;
  int           cycle_count = 0;
  int           gap_left = 0;
  logic         burst_mode = 1'b0;
  number_item_t next_item;
  token_t       due_tok;

  sort_and_condense_number_list uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_ref_value    (in_ref_value),
    .in_set_end      (in_set_end),
    .out_valid       (out_valid),
    .out_token_value (out_token_value),
    .out_separator   (out_separator),
    .out_overflow    (out_overflow),
    .out_final_token (out_final_token)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count++;
  endtask

  // Insert one number in ascending order; a full chain drops it and flags the set.
  function automatic void chain_insert(input logic [VALUE_BITS-1:0] v);
    int pos;
    if (list_count >= MAX_ENTRIES) begin
      list_dropped = 1'b1;
      return;
    end
    pos = list_count;
    while (pos > 0 && list_entries[pos-1] > v) pos--;
    for (int k = list_count; k > pos; k--) list_entries[k] = list_entries[k-1];
    list_entries[pos] = v;
    list_count++;
  endfunction

  // Walk the sorted chain and queue the tokens of the condensed list.
  function automatic void condense_list();
    int     i;
    int     cnt;
    longint v;
    token_t t;
    i = 0;
    cnt = list_count;
    while (i < cnt) begin
      v = list_entries[i];
      // A range needs both following entries to step by one; duplicates break it.
      if (i + 2 < cnt && longint'(list_entries[i+2]) == v + 2 &&
          longint'(list_entries[i+1]) == v + 1) begin
        while (i + 1 < cnt &&
               longint'(list_entries[i+1]) == longint'(list_entries[i]) + 1) i++;
        t.sep = SEP_DASH;
      end else begin
        i++;
        t.sep = (i < cnt) ? SEP_COMMA : SEP_NONE;
      end
      t.value = v[VALUE_BITS-1:0];
      t.overflow = list_dropped;
      t.last = (i >= cnt);
      tokens_due.push_back(t);
    end
    list_count = 0;
    list_dropped = 1'b0;
  endfunction

  function automatic void queue_number(input logic [VALUE_BITS-1:0] v, input logic last);
    number_item_t it;
    it.value = v;
    it.set_end = last;
    items_to_send.push_back(it);
  endfunction

  // Random set: mostly short sets of clustered values, sometimes an overfull one.
  function automatic void queue_random_set();
    int n;
    int mode;
    int base;
    logic [VALUE_BITS-1:0] v;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
    mode = $urandom_range(0, 3);
    base = (mode == 3) ? (int'(TOP_VALUE) + 1 - n - 3) : $urandom_range(0, 1000);
    for (int j = 0; j < n; j++) begin
      if (mode == 0) v = VALUE_BITS'($urandom);
      else v = VALUE_BITS'(base + int'($urandom_range(0, n + 2)));
      queue_number(v, j == n - 1);
    end
  endfunction

  // Mostly short gaps, a few long ones, and runs with no gaps at all.
  function automatic int next_gap();
    int r;
    if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: predicts on each accepted item, then offers the next one after a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        chain_insert(in_ref_value);
        if (in_set_end) condense_list();
        gap_left = next_gap();
      end
      if (!start || !busy) begin
        if (gap_left == 0 && items_to_send.size() > 0) begin
          next_item = items_to_send.pop_front();
          start <= 1'b1;
          in_ref_value <= next_item.value;
          in_set_end <= next_item.set_end;
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Monitor: every strobed token is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token value %0d", out_token_value));
      end else begin
        due_tok = tokens_due.pop_front();
        if (out_token_value !== due_tok.value)
          report_mismatch($sformatf("token value %0d, expected %0d",
                                    out_token_value, due_tok.value));
        if (out_separator !== due_tok.sep)
          report_mismatch($sformatf("separator %0d, expected %s",
                                    out_separator, due_tok.sep.name()));
        if (out_overflow !== due_tok.overflow)
          report_mismatch($sformatf("overflow %b, expected %b",
                                    out_overflow, due_tok.overflow));
        if (out_final_token !== due_tok.last)
          report_mismatch($sformatf("final token %b, expected %b",
                                    out_final_token, due_tok.last));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sort_and_condense_number_list: FAILED **");
      $finish;
    end
  end

  initial begin
    // Single number.
    queue_number(10'd5, 1'b1);
    // Both extremes, given in descending order.
    queue_number(TOP_VALUE, 1'b0);
    queue_number(10'd0, 1'b1);
    // Shortest range.
    queue_number(10'd5, 1'b0);
    queue_number(10'd3, 1'b0);
    queue_number(10'd4, 1'b1);
    // Two neighbors stay separate.
    queue_number(10'd8, 1'b0);
    queue_number(10'd7, 1'b1);
    // A duplicate value and a gap yield no range.
    queue_number(10'd3, 1'b0);
    queue_number(10'd1, 1'b0);
    queue_number(10'd1, 1'b1);
    // Range that ends at the top value.
    queue_number(TOP_VALUE, 1'b0);
    queue_number(TOP_VALUE - 10'd2, 1'b0);
    queue_number(TOP_VALUE - 10'd1, 1'b1);
    // Duplicate before a longer range.
    queue_number(10'd2, 1'b0);
    queue_number(10'd3, 1'b0);
    queue_number(10'd2, 1'b0);
    queue_number(10'd4, 1'b0);
    queue_number(10'd6, 1'b0);
    queue_number(10'd5, 1'b1);
    while (items_to_send.size() < 130) queue_random_set();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample between edges so the driver's updates have settled.
    while (items_to_send.size() != 0 || start) @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (tokens_due.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", tokens_due.size()));
    if (fail_count == 0) begin
      $display("** sort_and_condense_number_list: PASSED **");
    end else begin
      $display("** sort_and_condense_number_list: FAILED **");
    end
    $finish;
  end

endmodule
